// ----- sv/fgt_pkg.sv -----
// ============================================================================
// fgt_pkg
// Shared types and constants for the frame grant table: request and response
// payloads, request and status codes, controller states and the command and
// status groups between the controller and the datapath.
// ============================================================================
package fgt_pkg;

    // Fixed field widths of the request and response payloads.
    localparam int REQ_TYPE_W   = 3;
    localparam int DOMAIN_W     = 3;
    localparam int FRAME_W      = 16;
    localparam int RIGHTS_W     = 8;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 16;

    // Widest rights mask the storage supports.
    localparam int RIGHTS_MAX_W = 16;

    // Configuration port.
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 11;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_DOMAIN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [DOMAIN_W-1:0]   ROOT_DOMAIN_RESET = 3'd0;
    localparam logic [CFG_DATA_W-1:0] FRAME_COUNT_RESET = 11'd1024;

    // Saturation limits of the per-frame counters.
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ZERO = 16'h0000;

    // Request codes; the two unused codes are no-ops.
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_HOLDS      = 3'd0,
        REQ_ADD        = 3'd1,
        REQ_DROP       = 3'd2,
        REQ_MAP_ADD    = 3'd3,
        REQ_MAP_REMOVE = 3'd4,
        REQ_POOL_MARK  = 3'd5
    } t_req_type;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Request payload.
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [DOMAIN_W-1:0]   domain;
        logic [FRAME_W-1:0]    frame;
        logic [RIGHTS_W-1:0]   rights;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic                allowed;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  frame_refs;
    } t_rsp;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_READ  = 2'd2,
        S_EXEC  = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic clear_step;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage

// ----- sv/fgt_ctrl.sv -----
// ============================================================================
// fgt_ctrl
// Controller of the frame grant table: runs the clearing pass after reset,
// then steps each request through read, execute and result load.
// ============================================================================
module fgt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  fgt_pkg::t_sts i_sts,
    output fgt_pkg::t_cmd o_cmd
);
    import fgt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
            end
            S_READ: begin
                o_cmd = '0;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/fgt_datapath.sv -----
// ============================================================================
// fgt_datapath
// Datapath of the frame grant table: configuration registers, the grant,
// count, mapping and pool memories, the request logic and the result register.
// ============================================================================
module fgt_datapath #(
    parameter int NUM_DOMAINS = 8,
    parameter int NUM_FRAMES  = 1024,
    parameter int RIGHTS_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fgt_pkg::t_cmd                   i_cmd,
    output fgt_pkg::t_sts                   o_sts,
    input  fgt_pkg::t_req                   i_in_req,
    input  logic                            i_cfg_valid,
    input  logic [fgt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fgt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fgt_pkg::t_rsp                   o_out_rsp
);
    import fgt_pkg::*;

    localparam int DW     = $clog2(NUM_DOMAINS);
    localparam int FW     = $clog2(NUM_FRAMES);
    localparam int AW     = DW + FW;
    localparam int FDEPTH = 1 << FW;
    localparam int GDEPTH = NUM_DOMAINS * FDEPTH;
    localparam int GW     = RIGHTS_BITS + 1;

    // Reduces a domain number modulo NUM_DOMAINS by repeated subtraction.
    function automatic logic [DW-1:0] f_dom_mod(input logic [DOMAIN_W-1:0] v);
        logic [7:0] acc;
        acc = 8'(v);
        for (int i = 0; i < 8; i++) begin
            if (acc >= 8'(NUM_DOMAINS)) begin
                acc = acc - 8'(NUM_DOMAINS);
            end
        end
        return acc[DW-1:0];
    endfunction

    // Configuration registers, writable at any time.
    logic [DOMAIN_W-1:0]   r_root;
    logic [CFG_DATA_W-1:0] r_fcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root   <= ROOT_DOMAIN_RESET;
            r_fcount <= FRAME_COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROOT_DOMAIN: r_root   <= i_cfg_data[DOMAIN_W-1:0];
                CFG_FRAME_COUNT: r_fcount <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clearing pass address.
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_addr == AW'(GDEPTH - 1));

    // Request register, loaded on accept.
    t_req r_req;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_req;
        end
    end

    // Decoded request fields.
    logic [DW-1:0]           w_dom;
    logic [DW-1:0]           w_root;
    logic [FW-1:0]           w_frm;
    logic [AW-1:0]           w_gaddr;
    logic [RIGHTS_MAX_W-1:0] w_rights_ext;
    logic [RIGHTS_BITS-1:0]  w_rights;
    logic                    w_in_range;

    assign w_dom        = f_dom_mod(r_req.domain);
    assign w_root       = f_dom_mod(r_root);
    assign w_frm        = r_req.frame[FW-1:0];
    assign w_gaddr      = {w_dom, w_frm};
    assign w_rights_ext = RIGHTS_MAX_W'(r_req.rights);
    assign w_rights     = w_rights_ext[RIGHTS_BITS-1:0];
    assign w_in_range   = (r_req.frame < FRAME_W'(r_fcount))
                       && ({1'b0, r_req.frame} < (FRAME_W + 1)'(NUM_FRAMES));

    // Memories and their registered read data.
    logic [GW-1:0]      r_grant_mem [GDEPTH];
    logic [COUNT_W-1:0] r_gcnt_mem  [FDEPTH];
    logic [COUNT_W-1:0] r_mcnt_mem  [FDEPTH];
    logic               r_pool_mem  [FDEPTH];

    logic [GW-1:0]      r_grant_q;
    logic [COUNT_W-1:0] r_gcnt_q;
    logic [COUNT_W-1:0] r_mcnt_q;
    logic               r_pool_q;

    always_ff @(posedge i_clk) begin
        r_grant_q <= r_grant_mem[w_gaddr];
        r_gcnt_q  <= r_gcnt_mem[w_frm];
        r_mcnt_q  <= r_mcnt_mem[w_frm];
        r_pool_q  <= r_pool_mem[w_frm];
    end

    // Request execution: new entry, counter values and response.
    logic               w_valid_q;
    logic [GW-1:0]      w_grant_new;
    logic [COUNT_W-1:0] w_gcnt_new;
    logic [COUNT_W-1:0] w_mcnt_new;
    logic               w_grant_we;
    logic               w_gcnt_we;
    logic               w_mcnt_we;
    logic               w_pool_we;
    t_rsp               w_rsp;

    assign w_valid_q = r_grant_q[RIGHTS_BITS];

    always_comb begin
        w_grant_new    = r_grant_q;
        w_gcnt_new     = r_gcnt_q;
        w_mcnt_new     = r_mcnt_q;
        w_grant_we     = 1'b0;
        w_gcnt_we      = 1'b0;
        w_mcnt_we      = 1'b0;
        w_pool_we      = 1'b0;
        w_rsp.allowed  = 1'b0;
        w_rsp.status   = ST_OK;
        case (r_req.req_type)
            REQ_HOLDS: begin
                if (w_dom == w_root && r_pool_q && r_gcnt_q == COUNT_ZERO) begin
                    w_rsp.allowed = 1'b1;
                end else if (w_valid_q
                        && (r_grant_q[RIGHTS_BITS-1:0] & w_rights) == w_rights) begin
                    w_rsp.allowed = 1'b1;
                end
            end
            REQ_ADD: begin
                w_grant_we = 1'b1;
                if (w_valid_q) begin
                    w_grant_new = r_grant_q | {1'b0, w_rights};
                end else begin
                    w_grant_new = {1'b1, w_rights};
                    w_gcnt_we   = 1'b1;
                    if (r_gcnt_q != COUNT_MAX) begin
                        w_gcnt_new = r_gcnt_q + COUNT_W'(1);
                    end
                end
            end
            REQ_DROP: begin
                if (w_valid_q) begin
                    w_grant_we  = 1'b1;
                    w_grant_new = '0;
                    w_gcnt_we   = 1'b1;
                    if (r_gcnt_q != COUNT_ZERO) begin
                        w_gcnt_new = r_gcnt_q - COUNT_W'(1);
                    end
                end else begin
                    w_rsp.status = ST_NOT_FOUND;
                end
            end
            REQ_MAP_ADD: begin
                w_mcnt_we = 1'b1;
                if (r_mcnt_q != COUNT_MAX) begin
                    w_mcnt_new = r_mcnt_q + COUNT_W'(1);
                end
            end
            REQ_MAP_REMOVE: begin
                w_mcnt_we = 1'b1;
                if (r_mcnt_q != COUNT_ZERO) begin
                    w_mcnt_new = r_mcnt_q - COUNT_W'(1);
                end
            end
            REQ_POOL_MARK: begin
                w_pool_we = 1'b1;
            end
            default: begin
            end
        endcase
        w_rsp.frame_refs = w_gcnt_new;
        // An out-of-range frame is refused and changes nothing.
        if (!w_in_range) begin
            w_rsp.allowed    = 1'b0;
            w_rsp.status     = ST_RANGE;
            w_rsp.frame_refs = COUNT_ZERO;
            w_grant_we       = 1'b0;
            w_gcnt_we        = 1'b0;
            w_mcnt_we        = 1'b0;
            w_pool_we        = 1'b0;
        end
    end

    // Memory writes: clearing pass or request update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_grant_mem[r_clr_addr]         <= '0;
            r_gcnt_mem[r_clr_addr[FW-1:0]]  <= COUNT_ZERO;
            r_mcnt_mem[r_clr_addr[FW-1:0]]  <= COUNT_ZERO;
            r_pool_mem[r_clr_addr[FW-1:0]]  <= 1'b0;
        end else if (i_cmd.exec) begin
            if (w_grant_we) begin
                r_grant_mem[w_gaddr] <= w_grant_new;
            end
            if (w_gcnt_we) begin
                r_gcnt_mem[w_frm] <= w_gcnt_new;
            end
            if (w_mcnt_we) begin
                r_mcnt_mem[w_frm] <= w_mcnt_new;
            end
            if (w_pool_we) begin
                r_pool_mem[w_frm] <= 1'b1;
            end
        end
    end

    // Result register.
    logic r_out_valid;
    t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_rsp      = r_rsp;

endmodule

// ----- sv/frame_grant_table_unit.sv -----
// ============================================================================
// frame_grant_table_unit
// Per-domain physical frame grant table with grant, mapping and pool state.
// ============================================================================
// Requests enter on i_in_req with i_in_valid and are taken when o_in_stall is
// low; each request yields exactly one response on o_out_rsp with o_out_valid,
// taken when i_out_stall is low. Configuration writes (root domain, frame
// count) use i_cfg_valid and o_cfg_ready and are taken at any time.
// After reset the block runs a clearing pass, one entry per cycle, over all
// NUM_DOMAINS * 2**clog2(NUM_FRAMES) grant entries (8192 at the default
// sizes) and the count, mapping and pool memories; o_in_stall stays high
// until it finishes. An accepted request is held in the request register,
// then its memory reads are registered, then the memory update and the
// result load happen together, and wait while a stalled response holds
// the result register. Another request is accepted only after that update,
// because of the read-then-write on the grant and count memories.
// If the receiver stalls, the response waits in the output register and the
// next request is still accepted; its update waits until the register frees.
// ============================================================================
module frame_grant_table_unit #(
    parameter int NUM_DOMAINS = 8,
    parameter int NUM_FRAMES  = 1024,
    parameter int RIGHTS_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fgt_pkg::t_req                   i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fgt_pkg::t_rsp                   o_out_rsp,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fgt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fgt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fgt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Request sequencing.
    fgt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and request logic.
    fgt_datapath #(
        .NUM_DOMAINS (NUM_DOMAINS),
        .NUM_FRAMES  (NUM_FRAMES),
        .RIGHTS_BITS (RIGHTS_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_req    (i_in_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // Configuration registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_cmd.in_ready;

endmodule

// ----- test/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for frame_grant_table_unit. Each request is checked
// against a model of the grant table that the bench keeps itself. The model
// tracks per-domain entries, per-frame grant counts and pool bits. The bench
// starts with directed requests for the corner cases, then runs random phases
// under several root domain and frame count settings. Requests are sent in
// random bursts, and the response side stalls on a pattern of its own.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fgt_pkg::*;

    localparam int DOMAINS   = 8;
    localparam int FRAMES    = 1024;
    localparam int CYCLE_CAP = 200000;

    // Request codes with no defined operation.
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_HI = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_req                   in_req = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_rsp                   out_rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Model of the grant table state and configuration.
    bit                  grant_held [DOMAINS][FRAMES];
    bit [RIGHTS_W-1:0]   grant_mask [DOMAINS][FRAMES];
    bit [COUNT_W-1:0]    grant_refs [FRAMES];
    bit                  pool_frame [FRAMES];
    bit [DOMAIN_W-1:0]   root_dom = ROOT_DOMAIN_RESET;
    bit [CFG_DATA_W-1:0] frame_limit_cfg = FRAME_COUNT_RESET;

    t_req pending_requests[$];
    t_rsp pending_answers[$];
    int   requests_queued = 0;
    int   requests_taken = 0;
    int   error_count = 0;
    int   cycle_count = 0;
    bit   req_fired = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_tick = 0;
    int   stall_mode = 0;

    frame_grant_table_unit #(
        .NUM_DOMAINS (DOMAINS),
        .NUM_FRAMES  (FRAMES),
        .RIGHTS_BITS (RIGHTS_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one request to the model table and return the response it earns.
    function automatic t_rsp grant_table_apply(t_req r);
        t_rsp              rsp;
        int                lim;
        logic [9:0]        f;
        logic [DOMAIN_W-1:0] d;
        rsp = '0;
        lim = (frame_limit_cfg < FRAMES) ? int'(frame_limit_cfg) : FRAMES;
        if (int'(r.frame) >= lim) begin
            rsp.status = ST_RANGE;
            return rsp;
        end
        f = r.frame[9:0];
        d = r.domain;
        case (r.req_type)
            REQ_HOLDS: begin
                // The root domain owns pool frames that nobody holds a grant on.
                if (d == root_dom && pool_frame[f] && grant_refs[f] == COUNT_ZERO)
                    rsp.allowed = 1'b1;
                else if (grant_held[d][f] && (grant_mask[d][f] & r.rights) == r.rights)
                    rsp.allowed = 1'b1;
            end
            REQ_ADD: begin
                if (grant_held[d][f]) begin
                    grant_mask[d][f] |= r.rights;
                end else begin
                    grant_held[d][f] = 1'b1;
                    grant_mask[d][f] = r.rights;
                    if (grant_refs[f] != COUNT_MAX)
                        grant_refs[f]++;
                end
            end
            REQ_DROP: begin
                if (grant_held[d][f]) begin
                    grant_held[d][f] = 1'b0;
                    grant_mask[d][f] = '0;
                    if (grant_refs[f] != COUNT_ZERO)
                        grant_refs[f]--;
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            REQ_POOL_MARK: begin
                pool_frame[f] = 1'b1;
            end
            // Mapping counts never reach a response field, so map requests
            // and the spare codes leave the visible state alone.
            default: begin
            end
        endcase
        rsp.frame_refs = grant_refs[f];
        return rsp;
    endfunction

    task automatic queue_request(logic [REQ_TYPE_W-1:0] kind, logic [DOMAIN_W-1:0] dom,
                                 logic [FRAME_W-1:0] frame, logic [RIGHTS_W-1:0] rights);
        t_req r;
        r.req_type = kind;
        r.domain   = dom;
        r.frame    = frame;
        r.rights   = rights;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    // Random requests around a small window of frames so that entries get
    // added, queried and dropped again; a few land on the limit or anywhere.
    task automatic queue_random_requests(int n, int lim);
        int base;
        int pick;
        int kind_roll;
        logic [REQ_TYPE_W-1:0] kind;
        logic [DOMAIN_W-1:0]   dom;
        logic [FRAME_W-1:0]    frame;
        logic [RIGHTS_W-1:0]   rights;
        base = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0)
                base = $urandom_range(0, (lim > 12) ? lim - 12 : 0);
            kind_roll = $urandom_range(0, 99);
            if (kind_roll < 30)      kind = REQ_HOLDS;
            else if (kind_roll < 55) kind = REQ_ADD;
            else if (kind_roll < 75) kind = REQ_DROP;
            else if (kind_roll < 83) kind = REQ_POOL_MARK;
            else if (kind_roll < 89) kind = REQ_MAP_ADD;
            else if (kind_roll < 95) kind = REQ_MAP_REMOVE;
            else if (kind_roll < 97) kind = REQ_SPARE_LO;
            else                     kind = REQ_SPARE_HI;
            dom = ($urandom_range(0, 3) == 0) ? root_dom : DOMAIN_W'($urandom_range(0, 7));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                frame = FRAME_W'($urandom_range(0, 65535));
            else if (pick == 1)
                frame = FRAME_W'((lim > 0) ? lim - 1 : 0);
            else if (pick == 2)
                frame = FRAME_W'(lim);
            else
                frame = FRAME_W'(base + $urandom_range(0, 11));
            pick = $urandom_range(0, 19);
            if (pick < 2)      rights = '0;
            else if (pick < 4) rights = '1;
            else if (pick < 7) rights = RIGHTS_W'(1 << $urandom_range(0, RIGHTS_W - 1));
            else               rights = RIGHTS_W'($urandom_range(0, 255));
            queue_request(kind, dom, frame, rights);
        end
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_ROOT_DOMAIN)
            root_dom = value[DOMAIN_W-1:0];
        else
            frame_limit_cfg = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued request is taken and answered, then a margin.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (requests_taken != requests_queued || pending_answers.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [DOMAIN_W-1:0] root, logic [CFG_DATA_W-1:0] limit, int n);
        write_register(CFG_ROOT_DOMAIN, CFG_DATA_W'(root));
        write_register(CFG_FRAME_COUNT, limit);
        queue_random_requests(n, (limit < FRAMES) ? int'(limit) : FRAMES);
        wait_drained();
    endtask

    // Request driver: bursts of random length with random gaps in between.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !req_fired) begin
            // Hold the stalled request as it is.
        end else if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
            in_req   <= pending_requests.pop_front();
            in_valid <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Note each accepted request and predict its response.
    always @(posedge i_clk) begin
        req_fired = i_rst_n && in_valid && !in_stall;
        if (req_fired) begin
            pending_answers.push_back(grant_table_apply(in_req));
            requests_taken++;
        end
    end

    // Response stall: one of four patterns, picked anew at random by stall_tick.
    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 4);
            2: out_stall <= ((stall_tick % 5) < 2);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Response monitor: compare each accepted response with the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected response %h", $time, out_rsp);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (out_rsp.allowed !== want.allowed) begin
                    $display("%0t: allowed expected %0d actual %0d",
                             $time, want.allowed, out_rsp.allowed);
                    error_count++;
                end
                if (out_rsp.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_rsp.status);
                    error_count++;
                end
                if (out_rsp.frame_refs !== want.frame_refs) begin
                    $display("%0t: frame_refs expected %0d actual %0d",
                             $time, want.frame_refs, out_rsp.frame_refs);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset settings: root domain 0, all frames.
        write_register(CFG_ROOT_DOMAIN, CFG_DATA_W'(0));
        write_register(CFG_FRAME_COUNT, CFG_DATA_W'(FRAMES));
        queue_request(REQ_HOLDS, 3'd0, 16'd5, 8'hFF);        // root, frame not in pool
        queue_request(REQ_POOL_MARK, 3'd2, 16'd5, 8'h00);
        queue_request(REQ_HOLDS, 3'd0, 16'd5, 8'hFF);        // root rule applies
        queue_request(REQ_HOLDS, 3'd1, 16'd5, 8'h00);        // empty mask, no entry
        queue_request(REQ_ADD, 3'd1, 16'd5, 8'h81);
        queue_request(REQ_HOLDS, 3'd0, 16'd5, 8'h00);        // pool frame now referenced
        queue_request(REQ_HOLDS, 3'd1, 16'd5, 8'h01);
        queue_request(REQ_HOLDS, 3'd1, 16'd5, 8'h83);
        queue_request(REQ_HOLDS, 3'd1, 16'd5, 8'h00);        // empty mask, valid entry
        queue_request(REQ_ADD, 3'd1, 16'd5, 8'h02);          // rights merge into entry
        queue_request(REQ_HOLDS, 3'd1, 16'd5, 8'h83);
        queue_request(REQ_ADD, 3'd7, 16'd1023, 8'hFF);
        queue_request(REQ_ADD, 3'd6, 16'd1023, 8'h00);
        queue_request(REQ_DROP, 3'd3, 16'd5, 8'h00);         // no such grant
        queue_request(REQ_DROP, 3'd1, 16'd5, 8'h00);
        queue_request(REQ_HOLDS, 3'd0, 16'd5, 8'hFF);        // count back at zero
        queue_request(REQ_MAP_ADD, 3'd7, 16'd1023, 8'h00);
        queue_request(REQ_MAP_REMOVE, 3'd7, 16'd1023, 8'h00);
        queue_request(REQ_MAP_REMOVE, 3'd0, 16'd0, 8'h00);   // counter already zero
        queue_request(REQ_HOLDS, 3'd7, 16'd1024, 8'h00);     // first frame out of range
        queue_request(REQ_ADD, 3'd5, 16'hFFFF, 8'hFF);
        queue_request(REQ_SPARE_LO, 3'd7, 16'd1023, 8'hFF);
        queue_request(REQ_SPARE_HI, 3'd0, 16'd1023, 8'h00);
        queue_request(REQ_HOLDS, 3'd7, 16'd1023, 8'hFF);
        queue_request(REQ_HOLDS, 3'd6, 16'd1023, 8'h00);
        wait_drained();

        // Random phases over several settings, the extremes among them.
        queue_random_requests(250, FRAMES);
        wait_drained();
        run_phase(3'd7, 11'd0, 30);
        run_phase(3'd3, 11'd2047, 250);
        run_phase(3'd5, 11'd20, 200);
        run_phase(3'd7, 11'd1, 60);
        run_phase(3'd0, 11'd1023, 60);
        repeat (20) @(negedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
